>>> rtl/mrrb_pkg.sv
// Shared constants, codes and types of the multi-reader ring buffer.
`timescale 1ns / 1ps
package mrrb_pkg;

   // Ring size must be a power of two; pointers carry one extra wrap bit.
   localparam int BUFFER_BYTES = 4096;
   localparam int ADDR_W       = $clog2(BUFFER_BYTES);
   localparam int PTR_W        = ADDR_W + 1;
   localparam int READER_SLOTS = 4;
   localparam int SLOT_W       = 2;
   localparam int DATA_W       = 8;
   localparam int KIND_W       = 3;
   localparam int STATUS_W     = 3;
   localparam int COUNT_W      = 13;

   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = 1;
   localparam int QCNT_W       = 2;

   // Request kinds on the stream
   localparam logic [KIND_W-1:0] REQ_WRITE  = 3'd0;
   localparam logic [KIND_W-1:0] REQ_READ   = 3'd1;
   localparam logic [KIND_W-1:0] REQ_FLUSH  = 3'd2;
   localparam logic [KIND_W-1:0] REQ_ATTACH = 3'd3;
   localparam logic [KIND_W-1:0] REQ_DETACH = 3'd4;

   // Internal operation codes after classification
   localparam logic [2:0] OP_NOP    = 3'd0;
   localparam logic [2:0] OP_WRITE  = 3'd1;
   localparam logic [2:0] OP_READ   = 3'd2;
   localparam logic [2:0] OP_FLUSH  = 3'd3;
   localparam logic [2:0] OP_ATTACH = 3'd4;
   localparam logic [2:0] OP_DETACH = 3'd5;

   // Result status codes
   localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_INACTIVE  = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_NO_SLOT   = 3'd4;

   typedef struct packed {
      logic [2:0]        op;
      logic [SLOT_W-1:0] slot;
      logic [DATA_W-1:0] data;
   } q_entry_type;

endpackage

>>> rtl/mrrb_front.sv
// Front end: accepts request items and classifies them into queue entries.
`timescale 1ns / 1ps
module mrrb_front
   import mrrb_pkg::*;
(
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // data_in[7:0]
   input  logic [4:0]        req_tuser,   // req_type[2:0], reader_slot[4:3]
   input  logic              q_full,
   output logic              q_push,
   output q_entry_type       q_entry
);

   logic [KIND_W-1:0] kind;

   assign kind       = req_tuser[2:0];
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      q_entry.slot = req_tuser[4:3];
      q_entry.data = req_tdata[DATA_W-1:0];
      unique case (kind)
         REQ_WRITE:  q_entry.op = OP_WRITE;
         REQ_READ:   q_entry.op = OP_READ;
         REQ_FLUSH:  q_entry.op = OP_FLUSH;
         REQ_ATTACH: q_entry.op = OP_ATTACH;
         REQ_DETACH: q_entry.op = OP_DETACH;
         default:    q_entry.op = OP_NOP;
      endcase
   end

endmodule

>>> rtl/mrrb_queue.sv
// Short FIFO that decouples the front end from the back end.
`timescale 1ns / 1ps
module mrrb_queue
   import mrrb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  q_entry_type push_entry,
   output logic        full,
   input  logic        pop,
   output logic        valid,
   output q_entry_type head
);

   q_entry_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign full    = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign valid   = (cnt_ff != '0);
   assign head    = slot_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_in  = do_push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in  = do_pop ? rd_ff + QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_entry;
   end

endmodule

>>> rtl/mrrb_back.sv
// Back end: pointer state, byte memory, request execution and result register.
`timescale 1ns / 1ps
module mrrb_back
   import mrrb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         q_valid,
   input  q_entry_type  q_head,
   output logic         q_pop,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [23:0]  rsp_tdata,   // data_out[7:0], reclaimed_count[20:8], slot_out[22:21]
   output logic [2:0]   rsp_tuser    // status[2:0]
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RDATA = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rc_ptr_ff, rc_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff [READER_SLOTS];
   logic [PTR_W-1:0]    rd_ptr_in [READER_SLOTS];
   logic [READER_SLOTS-1:0] active_ff, active_in;
   logic [PTR_W-1:0]    dist_ff [READER_SLOTS];
   logic [PTR_W-1:0]    dist_in [READER_SLOTS];
   logic [PTR_W-1:0]    base_ff, base_in;

   logic                out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;
   logic [DATA_W-1:0]   out_data_ff, out_data_in;
   logic [COUNT_W-1:0]  out_count_ff, out_count_in;
   logic [SLOT_W-1:0]   out_slot_ff, out_slot_in;

   logic [DATA_W-1:0]   mem [BUFFER_BYTES];
   logic [DATA_W-1:0]   mem_q;
   logic                mem_we, mem_re;
   logic [ADDR_W-1:0]   mem_addr;

   logic [PTR_W-1:0]    used;
   logic [PTR_W-1:0]    sel_rd;
   logic [PTR_W-1:0]    best;
   logic                free_found;
   logic [SLOT_W-1:0]   free_idx;

   assign used   = wr_ptr_ff - rc_ptr_ff;
   assign sel_rd = rd_ptr_ff[q_head.slot];

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = READER_SLOTS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      best = base_ff;
      for (int i = 0; i < READER_SLOTS; i++) begin
         if (dist_ff[i] < best) best = dist_ff[i];
      end
   end

   always_comb begin
      state_in      = state_ff;
      wr_ptr_in     = wr_ptr_ff;
      rc_ptr_in     = rc_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      active_in     = active_ff;
      dist_in       = dist_ff;
      base_in       = base_ff;
      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_data_in   = out_data_ff;
      out_count_in  = out_count_ff;
      out_slot_in   = out_slot_ff;
      q_pop         = 1'b0;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_addr      = wr_ptr_ff[ADDR_W-1:0];

      if (out_valid_ff && rsp_tready) out_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && !out_valid_ff) begin
               q_pop         = 1'b1;
               out_valid_in  = 1'b1;
               out_status_in = STAT_OK;
               out_data_in   = '0;
               out_count_in  = '0;
               out_slot_in   = '0;
               unique case (q_head.op)
                  OP_WRITE: begin
                     if (used >= PTR_W'(BUFFER_BYTES)) begin
                        out_status_in = STAT_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        wr_ptr_in = wr_ptr_ff + PTR_W'(1);
                     end
                  end
                  OP_READ: begin
                     if (!active_ff[q_head.slot]) begin
                        out_status_in = STAT_INACTIVE;
                     end else if (sel_rd == wr_ptr_ff) begin
                        out_status_in = STAT_EMPTY;
                     end else begin
                        mem_re                 = 1'b1;
                        mem_addr               = sel_rd[ADDR_W-1:0];
                        rd_ptr_in[q_head.slot] = sel_rd + PTR_W'(1);
                        out_valid_in           = 1'b0;
                        state_in               = ST_RDATA;
                     end
                  end
                  OP_FLUSH: begin
                     base_in = used;
                     for (int i = 0; i < READER_SLOTS; i++) begin
                        dist_in[i] = active_ff[i] ? rd_ptr_ff[i] - rc_ptr_ff : used;
                     end
                     out_valid_in = 1'b0;
                     state_in     = ST_FLUSH;
                  end
                  OP_ATTACH: begin
                     if (!free_found) begin
                        out_status_in = STAT_NO_SLOT;
                     end else begin
                        active_in[free_idx] = 1'b1;
                        rd_ptr_in[free_idx] = rc_ptr_ff;
                        out_slot_in         = free_idx;
                     end
                  end
                  OP_DETACH: begin
                     if (!active_ff[q_head.slot]) out_status_in = STAT_INACTIVE;
                     else active_in[q_head.slot] = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_RDATA: begin
            out_valid_in = 1'b1;
            out_data_in  = mem_q;
            state_in     = ST_IDLE;
         end
         ST_FLUSH: begin
            out_valid_in = 1'b1;
            out_count_in = COUNT_W'(best);
            rc_ptr_in    = rc_ptr_ff + best;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_ptr_ff    <= '0;
         rc_ptr_ff    <= '0;
         active_ff    <= READER_SLOTS'(1);
         out_valid_ff <= 1'b0;
         for (int i = 0; i < READER_SLOTS; i++) rd_ptr_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         rc_ptr_ff    <= rc_ptr_in;
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
         rd_ptr_ff    <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff       <= dist_in;
      base_ff       <= base_in;
      out_status_ff <= out_status_in;
      out_data_ff   <= out_data_in;
      out_count_ff  <= out_count_in;
      out_slot_ff   <= out_slot_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= q_head.data;
      if (mem_re) mem_q <= mem[mem_addr];
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = {1'b0, out_slot_ff, out_count_ff, out_data_ff};

endmodule

>>> rtl/multi_reader_ring_buffer_top.sv
// Top level of the multi-reader byte ring buffer.
//
// Requests arrive on the req_ stream: req_tuser holds the request kind and
// reader slot, req_tdata the byte to append. Every request yields one result
// on the rsp_ stream: rsp_tuser holds the status, rsp_tdata the read byte,
// the reclaimed count of a flush and the slot granted by an attach.
// Accepted items enter a two-entry queue; the back end takes one item at a
// time once its result register is empty.
// Writes, attaches, detaches, unknown kinds and refused reads produce their
// result directly in the result register; a successful read passes through a
// registered memory read and a flush through a registered distance stage, then
// a minimum over the reader slots, before the result register.
// The back end takes no new item while a read or flush is in progress or while
// its result register still holds a result that has not been accepted.
// Reset clears all pointers, activates reader slot zero only and empties the
// queue; byte storage is not cleared. A stalled rsp_tready holds the result;
// the queue keeps accepting until both entries are taken.
`timescale 1ns / 1ps
module multi_reader_ring_buffer_top
   import mrrb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_in[7:0]
   input  logic [4:0]  req_tuser,   // req_type[2:0], reader_slot[4:3]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // data_out[7:0], reclaimed_count[20:8], slot_out[22:21]
   output logic [2:0]  rsp_tuser    // status[2:0]
);

   logic        q_full, q_push, q_valid, q_pop;
   q_entry_type q_entry, q_head;

   mrrb_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_entry)
   );

   mrrb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .valid      (q_valid),
      .head       (q_head)
   );

   mrrb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> rtl/mrrb_checker.sv
// Port-level assertions for the ring buffer top, bound to the top level.
`timescale 1ns / 1ps
module mrrb_checker
   import mrrb_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= STAT_NO_SLOT)
      else $error("status code out of range");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STAT_OK |-> rsp_tdata == 24'd0)
      else $error("refused request carries payload");

   a_one_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[7:0] != 8'd0 |-> rsp_tdata[22:8] == 15'd0)
      else $error("read result carries flush or attach payload");

   a_no_spurious: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result right after reset");

endmodule

bind multi_reader_ring_buffer_top mrrb_checker u_chk (.*);

>>> dv/tb.sv
// Self-checking stream testbench for the multi-reader ring buffer: directed and random items.
`timescale 1ns / 1ps
module tb;
   import mrrb_pkg::*;

   localparam int RANDOM_ITEMS   = 420;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_AT        = 200;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 12;
   localparam int PRINT_LIMIT    = 40;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   data;
      logic [COUNT_W-1:0]  freed;
      logic [SLOT_W-1:0]   slot;
   } ring_result_type;

   class ring_scoreboard;
      logic [DATA_W-1:0] ring_bytes [BUFFER_BYTES];
      logic [PTR_W-1:0]  wr_ptr;
      logic [PTR_W-1:0]  rec_ptr;
      logic [PTR_W-1:0]  rd_ptr [READER_SLOTS];
      bit                slot_busy [READER_SLOTS];
      ring_result_type   pending_results [$];
      int                errors;
      int                checked;
      int                refused_writes;
      int                bytes_fetched;
      int                bytes_freed;

      function new();
         wr_ptr  = '0;
         rec_ptr = '0;
         foreach (rd_ptr[i]) begin
            rd_ptr[i]    = '0;
            slot_busy[i] = (i == 0);
         end
         errors         = 0;
         checked        = 0;
         refused_writes = 0;
         bytes_fetched  = 0;
         bytes_freed    = 0;
      endfunction

      function logic [PTR_W-1:0] span(input logic [PTR_W-1:0] from, input logic [PTR_W-1:0] to);
         return PTR_W'(to - from);
      endfunction

      function bit is_full();
         return span(rec_ptr, wr_ptr) >= BUFFER_BYTES;
      endfunction

      // random slot, biased toward an active one
      function logic [SLOT_W-1:0] pick_slot();
         logic [SLOT_W-1:0] s;
         s = SLOT_W'($urandom_range(0, READER_SLOTS - 1));
         if ($urandom_range(0, 4) != 0)
            for (int n = 0; n < READER_SLOTS && !slot_busy[s]; n++) s = s + 1'b1;
         return s;
      endfunction

      task note_request(input logic [KIND_W-1:0] kind, input logic [SLOT_W-1:0] slot,
                        input logic [DATA_W-1:0] din);
         ring_result_type  res;
         logic [PTR_W-1:0] least;
         bit               found;
         res   = '0;
         found = 1'b0;
         case (kind)
            REQ_WRITE: begin
               if (is_full()) begin
                  res.status = STAT_FULL;
                  refused_writes++;
               end else begin
                  ring_bytes[wr_ptr[ADDR_W-1:0]] = din;
                  wr_ptr = wr_ptr + 1'b1;
               end
            end
            REQ_READ: begin
               if (!slot_busy[slot]) begin
                  res.status = STAT_INACTIVE;
               end else if (rd_ptr[slot] == wr_ptr) begin
                  res.status = STAT_EMPTY;
               end else begin
                  res.data     = ring_bytes[rd_ptr[slot][ADDR_W-1:0]];
                  rd_ptr[slot] = rd_ptr[slot] + 1'b1;
                  bytes_fetched++;
               end
            end
            REQ_FLUSH: begin
               least = span(rec_ptr, wr_ptr);
               for (int i = 0; i < READER_SLOTS; i++)
                  if (slot_busy[i] && span(rec_ptr, rd_ptr[i]) < least)
                     least = span(rec_ptr, rd_ptr[i]);
               res.freed = least;
               rec_ptr   = rec_ptr + least;
               bytes_freed += least;
            end
            REQ_ATTACH: begin
               res.status = STAT_NO_SLOT;
               for (int i = 0; i < READER_SLOTS; i++) begin
                  if (!found && !slot_busy[i]) begin
                     found        = 1'b1;
                     slot_busy[i] = 1'b1;
                     rd_ptr[i]    = rec_ptr;
                     res.slot     = SLOT_W'(i);
                     res.status   = STAT_OK;
                  end
               end
            end
            REQ_DETACH: begin
               if (!slot_busy[slot]) res.status = STAT_INACTIVE;
               else slot_busy[slot] = 1'b0;
            end
            default: ;
         endcase
         pending_results.push_back(res);
      endtask

      task report(input string msg);
         errors++;
         if (errors <= PRINT_LIMIT) $display("mismatch at %0t: %s", $time, msg);
      endtask

      task check_result(input logic [STATUS_W-1:0] user, input logic [23:0] tdata);
         ring_result_type want;
         checked++;
         if (pending_results.size() == 0) begin
            report($sformatf("unexpected result, status %0d tdata %h", user, tdata));
            return;
         end
         want = pending_results.pop_front();
         if (user !== want.status)
            report($sformatf("item %0d status %0d, want %0d", checked, user, want.status));
         if (tdata[7:0] !== want.data)
            report($sformatf("item %0d data %h, want %h", checked, tdata[7:0], want.data));
         if (tdata[20:8] !== want.freed)
            report($sformatf("item %0d freed %0d, want %0d", checked, tdata[20:8], want.freed));
         if (tdata[22:21] !== want.slot)
            report($sformatf("item %0d slot %0d, want %0d", checked, tdata[22:21], want.slot));
      endtask
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // data_in[7:0]
   logic [4:0]  req_tuser  = '0;   // req_type[2:0], reader_slot[4:3]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // data_out[7:0], reclaimed_count[20:8], slot_out[22:21]
   logic [2:0]  rsp_tuser;         // status[2:0]

   ring_scoreboard board;
   bit req_idle_on = 1'b1;

   multi_reader_ring_buffer_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   function automatic int idle_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
   endfunction

   // result side: random stalls plus one long hold-off
   int hold_left  = 0;
   int stall_left = 0;
   int rsp_phase  = 0;
   bit rsp_idle_on = 1'b1;
   bit hold_done   = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tuser, rsp_tdata);
         if (!hold_done && board.checked >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         rsp_phase++;
         if (rsp_phase % 128 == 0) rsp_idle_on = ($urandom_range(0, 3) != 0);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (rsp_idle_on && $urandom_range(0, 3) == 0) stall_left = idle_length();
         end
      end
   end

   int quiet = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("tb NOT OK");
            $finish;
         end
      end
   end

   task automatic push_request(input logic [KIND_W-1:0] kind, input logic [SLOT_W-1:0] slot,
                               input logic [DATA_W-1:0] din);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= {slot, kind};
      req_tdata  <= din;
      do @(posedge clock); while (!req_tready);
      board.note_request(kind, slot, din);
      if ($urandom_range(0, 63) == 0) req_idle_on = !req_idle_on;
      gap = (req_idle_on && $urandom_range(0, 2) == 0) ? idle_length() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin : stimulus
      int                pick;
      logic [KIND_W-1:0] kind;
      board = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: refusals, unknown kinds, field extremes, slot bookkeeping
      push_request(REQ_READ, 2'd0, 8'h00);
      push_request(REQ_READ, 2'd2, 8'hFF);
      push_request(REQ_DETACH, 2'd3, 8'h00);
      push_request(KIND_W'(int'(REQ_DETACH) + 1), 2'd3, 8'hFF);
      push_request(KIND_W'(int'(REQ_DETACH) + 2), 2'd1, 8'h3C);
      push_request(KIND_W'((1 << KIND_W) - 1), 2'd0, 8'h00);
      push_request(REQ_WRITE, 2'd3, 8'h00);
      push_request(REQ_WRITE, 2'd0, 8'hFF);
      push_request(REQ_WRITE, 2'd1, 8'h5A);
      repeat (4) push_request(REQ_READ, 2'd0, 8'h00);
      repeat (4) push_request(REQ_ATTACH, 2'd0, 8'h00);
      push_request(REQ_FLUSH, 2'd0, 8'h00);
      push_request(REQ_READ, 2'd3, 8'h00);
      push_request(REQ_DETACH, 2'd1, 8'h00);
      push_request(REQ_DETACH, 2'd2, 8'h00);
      push_request(REQ_DETACH, 2'd2, 8'h00);
      push_request(REQ_FLUSH, 2'd3, 8'hFF);
      push_request(REQ_DETACH, 2'd3, 8'h00);
      push_request(REQ_DETACH, 2'd0, 8'h00);
      push_request(REQ_FLUSH, 2'd0, 8'h00);
      push_request(REQ_READ, 2'd0, 8'h00);

      repeat (RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) kind = REQ_WRITE;
         else if (pick < 72) kind = REQ_READ;
         else if (pick < 80) kind = REQ_FLUSH;
         else if (pick < 88) kind = REQ_ATTACH;
         else if (pick < 96) kind = REQ_DETACH;
         else kind = KIND_W'($urandom_range(int'(REQ_DETACH) + 1, (1 << KIND_W) - 1));
         push_request(kind, board.pick_slot(), DATA_W'($urandom));
      end
      req_tvalid <= 1'b0;

      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d results checked, %0d mismatches, incl. a long receiver hold-off",
               board.checked, board.errors);
      $display("summary: %0d refused writes, %0d bytes read back, %0d bytes reclaimed",
               board.refused_writes, board.bytes_fetched, board.bytes_freed);
      if (board.errors == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/mrrb_pkg.sv
rtl/mrrb_front.sv
rtl/mrrb_queue.sv
rtl/mrrb_back.sv
rtl/multi_reader_ring_buffer_top.sv
rtl/mrrb_checker.sv
dv/tb.sv
